>>> rtl/pvm_pkg.sv
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared command codes, sample limits and field widths of the voice mixer.
// ----------------------------------------------------------------------------
package pvm_pkg;

	// Command codes carried by the request channel.
	typedef enum logic [1:0] {
		OP_WRITE_SAMPLE = 2'd0,
		OP_WRITE_DESC   = 2'd1,
		OP_TRIGGER      = 2'd2,
		OP_MIX          = 2'd3
	} opcode_t;

	// Fixed field widths of the request and result items.
	localparam int INDEX_W   = 5;
	localparam int MASK_W    = 32;
	localparam int ADDR_W    = 16;
	localparam int SAMPLE_W  = 16;
	localparam int LENGTH_W  = 17;
	localparam int SHOWN_W   = 4;

	// Saturation limits of the mixed output.
	localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 16'sh8000;

endpackage

>>> rtl/pvm_if.sv
// ----------------------------------------------------------------------------
// pvm_if
// Request and result channel interfaces of the voice mixer.
// ----------------------------------------------------------------------------
interface pvm_cmd_if;
	logic                                     valid;
	logic                                     ready;
	pvm_pkg::opcode_t                         opcode;
	logic [pvm_pkg::INDEX_W-1:0]              sound_index;
	logic [pvm_pkg::MASK_W-1:0]               trigger_mask;
	logic [pvm_pkg::ADDR_W-1:0]               mem_address;
	logic signed [pvm_pkg::SAMPLE_W-1:0]      sample_value;
	logic [pvm_pkg::LENGTH_W-1:0]             sound_length;
	logic                                     sound_valid;

	modport source (output valid, opcode, sound_index, trigger_mask, mem_address,
		sample_value, sound_length, sound_valid, input ready);
	modport sink (input valid, opcode, sound_index, trigger_mask, mem_address,
		sample_value, sound_length, sound_valid, output ready);
endinterface

interface pvm_res_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pvm_pkg::SAMPLE_W-1:0]      mixed_sample;
	logic                                     clipped;
	logic [pvm_pkg::SHOWN_W-1:0]              active_voices;

	modport source (output valid, mixed_sample, clipped, active_voices, input ready);
	modport sink (input valid, mixed_sample, clipped, active_voices, output ready);
endinterface

>>> rtl/pcm_voice_mixer_unit.sv
// ----------------------------------------------------------------------------
// pcm_voice_mixer_unit
// Sample-playback mixer with a sample memory, a sound descriptor table and
// a small set of voices that are summed into one saturated PCM sample.
// ----------------------------------------------------------------------------
// Usage: requests enter on the cmd channel and mixed samples leave on the
// result channel; both use a valid/ready handshake. Only a mix request
// produces a result; write and trigger requests produce none.
// A sample write runs the address reduction, RED_SHIFT + 1 steps (none when
// SAMPLE_DEPTH exceeds 65535), and then commits; a descriptor write does the
// same. A trigger request scans the descriptor memory one sound per cycle.
// A mix request walks the voices one per cycle through the single read port
// of the sample memory. One request is in flight at a time; cmd.ready is
// high while the engine is waiting for work.
// The result sits in an output register, so the engine keeps taking requests
// while it waits; the next mix runs its voice walk and then stalls, holding
// cmd.ready low, until the receiver takes the older result.
// Reset clears the voices, the descriptor valid bits and the output valid
// bit. The sample memory and descriptor fields are not cleared; a
// sound must be loaded before it is played.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_unit #(
	parameter int VOICE_COUNT  = 4,
	parameter int SOUND_COUNT  = 32,
	parameter int SAMPLE_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	pvm_cmd_if.sink     cmd,
	pvm_res_if.source   result
);

	localparam int AW   = $clog2(SAMPLE_DEPTH);
	localparam int SW   = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
	localparam int VW   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int LW   = pvm_pkg::LENGTH_W;
	localparam int DW   = AW + LW;
	localparam int ACCW = pvm_pkg::SAMPLE_W + 1 + $clog2(VOICE_COUNT + 1);

	// Addresses are reduced modulo the depth by restoring subtraction of
	// shifted copies of the depth, one per cycle, largest first.
	localparam bit RED_NEEDED = (SAMPLE_DEPTH <= 65535);
	localparam int RED_SHIFT  = RED_NEEDED ? $clog2(65536 / SAMPLE_DEPTH) : 0;
	localparam logic [17:0] RED_DIV0 = 18'(SAMPLE_DEPTH << RED_SHIFT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(SAMPLE_DEPTH - 1);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b00000001,
		ST_REDUCE  = 8'b00000010,
		ST_COMMIT  = 8'b00000100,
		ST_SCAN    = 8'b00001000,
		ST_TDRAIN  = 8'b00010000,
		ST_MIX     = 8'b00100000,
		ST_MDRAIN  = 8'b01000000,
		ST_OUT     = 8'b10000000
	} state_t;

	state_t state_q;

	// Captured request.
	pvm_pkg::opcode_t                   op_q;
	logic [SW-1:0]                      idx_q;
	logic [SOUND_COUNT-1:0]             mask_q;
	logic [pvm_pkg::SAMPLE_W-1:0]       wval_q;
	logic [LW-1:0]                      wlen_q;
	logic                               wvalid_q;

	// Address reduction.
	logic [15:0]                        r_q;
	logic [17:0]                        div_q;
	logic [3:0]                         red_cnt_q;

	// Sequencing counters.
	logic [SW-1:0]                      scan_q;
	logic [VW-1:0]                      vcnt_q;

	// Descriptor valid bits and voice registers.
	logic [SOUND_COUNT-1:0]             dvalid_q;
	logic [VOICE_COUNT-1:0]             busy_q;
	logic [AW-1:0]                      vaddr_q [VOICE_COUNT];
	logic [LW-1:0]                      vpos_q  [VOICE_COUNT];
	logic [LW-1:0]                      vlen_q  [VOICE_COUNT];

	// Memories and their registered read data.
	logic [pvm_pkg::SAMPLE_W-1:0]       smem [SAMPLE_DEPTH];
	logic [DW-1:0]                      dmem [SOUND_COUNT];
	logic signed [pvm_pkg::SAMPLE_W-1:0] srd_s1;
	logic [DW-1:0]                      drd_s1;

	// Pipeline flags for the cycle after a memory read.
	logic                               hit_s1;
	logic                               add_s1;
	logic signed [ACCW-1:0]             acc_q;

	// Output register.
	logic                               out_valid_q;
	logic signed [pvm_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                               out_clip_q;
	logic [pvm_pkg::SHOWN_W-1:0]        out_active_q;

	logic                               cmd_fire;
	logic                               idx_in_range;
	logic                               free_found;
	logic [VW-1:0]                      free_idx;
	logic                               voice_plays;
	logic                               out_load;
	logic [VOICE_COUNT+pvm_pkg::SHOWN_W-1:0] busy_wide;
	logic signed [pvm_pkg::SAMPLE_W-1:0] sat_sample;
	logic                               sat_clip;
	logic [AW-1:0]                      red_addr;

	assign cmd.ready    = (state_q == ST_IDLE);
	assign cmd_fire     = cmd.valid && cmd.ready;
	assign idx_in_range = ({1'b0, cmd.sound_index} < 6'(SOUND_COUNT));
	assign red_addr     = AW'(r_q);

	// The lowest voice that is not playing.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = VW'(i);
			end
		end
	end

	assign voice_plays = busy_q[vcnt_q] && (vpos_q[vcnt_q] < vlen_q[vcnt_q]);

	// Saturation of the finished sum.
	always_comb begin
		if (acc_q > ACCW'(pvm_pkg::PCM_MAX)) begin
			sat_sample = pvm_pkg::PCM_MAX;
			sat_clip   = 1'b1;
		end else if (acc_q < ACCW'(pvm_pkg::PCM_MIN)) begin
			sat_sample = pvm_pkg::PCM_MIN;
			sat_clip   = 1'b1;
		end else begin
			sat_sample = acc_q[pvm_pkg::SAMPLE_W-1:0];
			sat_clip   = 1'b0;
		end
	end

	assign busy_wide = (VOICE_COUNT + pvm_pkg::SHOWN_W)'(busy_q);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	// Sample memory: written by a committed sample write, read by the mix walk.
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT && op_q == pvm_pkg::OP_WRITE_SAMPLE) begin
			smem[red_addr] <= wval_q;
		end
		srd_s1 <= smem[vaddr_q[vcnt_q]];
	end

	// Descriptor memory: start address already reduced, and length.
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT && op_q == pvm_pkg::OP_WRITE_DESC) begin
			dmem[idx_q] <= {red_addr, wlen_q};
		end
		drd_s1 <= dmem[scan_q];
	end

	// Request capture and payload registers that need no reset.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q     <= cmd.opcode;
			idx_q    <= SW'(cmd.sound_index);
			mask_q   <= SOUND_COUNT'(cmd.trigger_mask);
			wval_q   <= cmd.sample_value;
			wlen_q   <= cmd.sound_length;
			wvalid_q <= cmd.sound_valid;
		end
		if (out_load) begin
			out_sample_q <= sat_sample;
			out_clip_q   <= sat_clip;
			out_active_q <= busy_wide[pvm_pkg::SHOWN_W-1:0];
		end
	end

	// Control, reduction, voices and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r_q         <= '0;
			div_q       <= '0;
			red_cnt_q   <= '0;
			scan_q      <= '0;
			vcnt_q      <= '0;
			dvalid_q    <= '0;
			busy_q      <= '0;
			hit_s1      <= 1'b0;
			add_s1      <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				vaddr_q[i] <= '0;
				vpos_q[i]  <= '0;
				vlen_q[i]  <= '0;
			end
		end else begin
			hit_s1 <= (state_q == ST_SCAN) && mask_q[scan_q] && dvalid_q[scan_q];
			add_s1 <= (state_q == ST_MIX) && voice_plays;
			if (add_s1) begin
				acc_q <= acc_q + ACCW'(srd_s1);
			end

			// A descriptor read in the previous cycle claims the lowest free voice.
			if (hit_s1 && free_found) begin
				busy_q[free_idx]  <= 1'b1;
				vaddr_q[free_idx] <= drd_s1[DW-1:LW];
				vlen_q[free_idx]  <= drd_s1[LW-1:0];
				vpos_q[free_idx]  <= '0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						r_q       <= cmd.mem_address;
						div_q     <= RED_DIV0;
						red_cnt_q <= 4'(RED_SHIFT);
						scan_q    <= '0;
						vcnt_q    <= '0;
						acc_q     <= '0;
						case (cmd.opcode)
							pvm_pkg::OP_WRITE_SAMPLE: begin
								state_q <= RED_NEEDED ? ST_REDUCE : ST_COMMIT;
							end
							pvm_pkg::OP_WRITE_DESC: begin
								if (idx_in_range) begin
									state_q <= RED_NEEDED ? ST_REDUCE : ST_COMMIT;
								end
							end
							pvm_pkg::OP_TRIGGER: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_MIX;
							end
						endcase
					end
				end
				ST_REDUCE: begin
					if ({2'b00, r_q} >= div_q) begin
						r_q <= r_q - div_q[15:0];
					end
					div_q     <= div_q >> 1;
					red_cnt_q <= red_cnt_q - 4'd1;
					if (red_cnt_q == 4'd0) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (op_q == pvm_pkg::OP_WRITE_DESC) begin
						dvalid_q[idx_q] <= wvalid_q;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					scan_q <= scan_q + SW'(1);
					if (scan_q == SW'(SOUND_COUNT - 1)) begin
						state_q <= ST_TDRAIN;
					end
				end
				ST_TDRAIN: begin
					state_q <= ST_IDLE;
				end
				ST_MIX: begin
					if (busy_q[vcnt_q]) begin
						if (voice_plays) begin
							vpos_q[vcnt_q]  <= vpos_q[vcnt_q] + LW'(1);
							vaddr_q[vcnt_q] <= (vaddr_q[vcnt_q] == LAST_ADDR) ? '0
								: vaddr_q[vcnt_q] + AW'(1);
						end else begin
							busy_q[vcnt_q]  <= 1'b0;
							vaddr_q[vcnt_q] <= '0;
							vpos_q[vcnt_q]  <= '0;
							vlen_q[vcnt_q]  <= '0;
						end
					end
					vcnt_q <= vcnt_q + VW'(1);
					if (vcnt_q == VW'(VOICE_COUNT - 1)) begin
						state_q <= ST_MDRAIN;
					end
				end
				ST_MDRAIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.mixed_sample  = out_sample_q;
	assign result.clipped       = out_clip_q;
	assign result.active_voices = out_active_q;

	// A mix request always starts the voice walk in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && cmd.opcode == pvm_pkg::OP_MIX |=> state_q == ST_MIX)
		else $error("mix request did not start the voice walk");

	// Sample data is summed only in the cycle after a voice walk step.
	assert property (@(posedge clk) disable iff (!arst_n)
		add_s1 |-> $past(state_q) == ST_MIX)
		else $error("accumulate outside the voice walk");

	// A new result appears only when the output stage loads it.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result valid raised outside the output stage");

	// The reduced address lies inside the sample memory at commit.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |-> 32'(r_q) < SAMPLE_DEPTH)
		else $error("address reduction left a value at or above the depth");

endmodule
